// ----- sv/hrds_pkg.sv -----
// Shared types and constants for the HID report descriptor size scan.
// No dependencies; every other file of the block imports this package.
package hrds_pkg;

   localparam int ACC_W          = 32;   // payload accumulator width
   localparam int MAX_W          = 61;   // report byte count width
   localparam int SUM_W          = 2 * ACC_W + 2;
   localparam int VALUE_BITS_DEF = 32;

   // Item prefix codes
   localparam logic [7:0] PFX_REPORT_ID    = 8'h85;
   localparam logic [7:0] PFX_LONG_MARK    = 8'hF0;
   localparam logic [7:0] KEY_MASK         = 8'hFC;
   localparam logic [7:0] KEY_REPORT_SIZE  = 8'h74;
   localparam logic [7:0] KEY_REPORT_COUNT = 8'h94;
   localparam logic [7:0] KEY_INPUT        = 8'h80;
   localparam logic [7:0] KEY_OUTPUT       = 8'h90;
   localparam logic [1:0] SIZE_CODE_MASK   = 2'h3;
   localparam logic [1:0] SIZE_CODE_FOUR   = 2'h3;

   typedef struct packed {
      logic [7:0] desc_byte;
      logic       last_byte;
   } hrds_req_type;

   typedef struct packed {
      logic             parse_ok;
      logic [MAX_W-1:0] max_input_bytes;
      logic [MAX_W-1:0] max_output_bytes;
      logic             uses_report_id;
   } hrds_rsp_type;

   // One parsed byte as seen by the size stage
   typedef struct packed {
      logic             valid;
      logic             is_input;
      logic             is_output;
      logic             last;
      logic             ok;
      logic             rid_seen;
      logic [ACC_W-1:0] size;
      logic [ACC_W-1:0] count;
   } hrds_event_type;

endpackage

// ----- sv/hrds_parser.sv -----
// Input register, item parser state machine and event register.
// Depends on hrds_pkg.
module hrds_parser #(
   parameter int VALUE_BITS = hrds_pkg::VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   req_valid,
   input  hrds_pkg::hrds_req_type req_word,
   output hrds_pkg::hrds_event_type ev
);
   import hrds_pkg::*;

   typedef enum logic [4:0] {
      PH_PREFIX    = 5'b00001,
      PH_LONG_LEN  = 5'b00010,
      PH_LONG_TAG  = 5'b00100,
      PH_LONG_SKIP = 5'b01000,
      PH_SHORT     = 5'b10000
   } hrds_phase_type;

   logic                  s1_valid_ff;
   hrds_req_type          s1_word_ff;

   hrds_phase_type        phase_ff, phase_in;
   logic [7:0]            prefix_ff, prefix_in;
   logic [7:0]            left_ff, left_in;
   logic [1:0]            idx_ff, idx_in;
   logic [ACC_W-1:0]      accum_ff, accum_in;
   logic [7:0]            rid_ff, rid_in;
   logic [VALUE_BITS-1:0] cur_size_ff, cur_size_in;
   logic [VALUE_BITS-1:0] cur_count_ff, cur_count_in;
   logic [VALUE_BITS-1:0] g_size_ff, g_size_in;
   logic [VALUE_BITS-1:0] g_count_ff, g_count_in;
   logic                  rid_seen_ff, rid_seen_in;

   logic                  ev_valid_ff;
   hrds_event_type        ev_ff, ev_in;

   logic                  complete;
   logic [7:0]            b;
   logic [7:0]            key;
   logic [VALUE_BITS-1:0] v;
   logic [2:0]            n;

   assign b = s1_word_ff.desc_byte;

   always_comb begin
      phase_in     = phase_ff;
      prefix_in    = prefix_ff;
      left_in      = left_ff;
      idx_in       = idx_ff;
      accum_in     = accum_ff;
      rid_in       = rid_ff;
      cur_size_in  = cur_size_ff;
      cur_count_in = cur_count_ff;
      g_size_in    = g_size_ff;
      g_count_in   = g_count_ff;
      rid_seen_in  = rid_seen_ff;
      complete     = 1'b0;
      n            = {1'b0, b[1:0] & SIZE_CODE_MASK};
      if ((b[1:0] & SIZE_CODE_MASK) == SIZE_CODE_FOUR) begin
         n = 3'd4;
      end

      unique case (phase_ff)
         PH_LONG_LEN: begin
            left_in  = b;
            phase_in = PH_LONG_TAG;
         end
         PH_LONG_TAG: begin
            if (left_ff == 8'd0) begin
               complete = 1'b1;
            end else begin
               phase_in = PH_LONG_SKIP;
            end
         end
         PH_LONG_SKIP: begin
            left_in  = left_ff - 8'd1;
            complete = (left_in == 8'd0);
         end
         PH_SHORT: begin
            accum_in = accum_ff | (ACC_W'(b) << {idx_ff, 3'b000});
            idx_in   = idx_ff + 2'd1;
            left_in  = left_ff - 8'd1;
            complete = (left_in == 8'd0);
         end
         default: begin
            prefix_in = b;
            accum_in  = '0;
            idx_in    = 2'd0;
            left_in   = 8'd0;
            if (b == PFX_REPORT_ID) begin
               rid_seen_in = 1'b1;
            end
            if ((b & PFX_LONG_MARK) == PFX_LONG_MARK) begin
               phase_in = PH_LONG_LEN;
            end else if (n == 3'd0) begin
               complete = 1'b1;
            end else begin
               left_in  = {5'd0, n};
               phase_in = PH_SHORT;
            end
         end
      endcase

      // apply a finished item
      key = prefix_in & KEY_MASK;
      v   = accum_in[VALUE_BITS-1:0];
      ev_in           = '0;
      ev_in.valid     = s1_valid_ff;
      ev_in.size      = ACC_W'(cur_size_ff);
      ev_in.count     = ACC_W'(cur_count_ff);
      if (complete) begin
         phase_in = PH_PREFIX;
         if (prefix_in == PFX_REPORT_ID) begin
            rid_in       = accum_in[7:0];
            cur_size_in  = g_size_ff;
            cur_count_in = g_count_ff;
         end else if (key == KEY_REPORT_SIZE) begin
            cur_size_in = v;
            if (rid_ff == 8'd0) begin
               g_size_in = v;
            end
         end else if (key == KEY_REPORT_COUNT) begin
            cur_count_in = v;
            if (rid_ff == 8'd0) begin
               g_count_in = v;
            end
         end else if (key == KEY_INPUT) begin
            ev_in.is_input = 1'b1;
         end else if (key == KEY_OUTPUT) begin
            ev_in.is_output = 1'b1;
         end
      end
      ev_in.last     = s1_word_ff.last_byte;
      ev_in.ok       = complete;
      ev_in.rid_seen = rid_seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         ev_valid_ff  <= 1'b0;
         phase_ff     <= PH_PREFIX;
         prefix_ff    <= '0;
         left_ff      <= '0;
         idx_ff       <= '0;
         accum_ff     <= '0;
         rid_ff       <= '0;
         cur_size_ff  <= '0;
         cur_count_ff <= '0;
         g_size_ff    <= '0;
         g_count_ff   <= '0;
         rid_seen_ff  <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         ev_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            if (s1_word_ff.last_byte) begin
               // end of descriptor: start clean
               phase_ff     <= PH_PREFIX;
               prefix_ff    <= '0;
               left_ff      <= '0;
               idx_ff       <= '0;
               accum_ff     <= '0;
               rid_ff       <= '0;
               cur_size_ff  <= '0;
               cur_count_ff <= '0;
               g_size_ff    <= '0;
               g_count_ff   <= '0;
               rid_seen_ff  <= 1'b0;
            end else begin
               phase_ff     <= phase_in;
               prefix_ff    <= prefix_in;
               left_ff      <= left_in;
               idx_ff       <= idx_in;
               accum_ff     <= accum_in;
               rid_ff       <= rid_in;
               cur_size_ff  <= cur_size_in;
               cur_count_ff <= cur_count_in;
               g_size_ff    <= g_size_in;
               g_count_ff   <= g_count_in;
               rid_seen_ff  <= rid_seen_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_word_ff <= req_word;
         ev_ff      <= ev_in;
      end
   end

   always_comb begin
      ev       = ev_ff;
      ev.valid = ev_valid_ff;
   end

endmodule

// ----- sv/hrds_size_max.sv -----
// Report size multiply stage, running maxima and result register.
// Depends on hrds_pkg.
module hrds_size_max #(
   parameter int VALUE_BITS = hrds_pkg::VALUE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  hrds_pkg::hrds_event_type ev,
   input  logic                     rsp_stall,
   output logic                     s3_result,
   output logic                     rsp_valid,
   output hrds_pkg::hrds_rsp_type   rsp_word
);
   import hrds_pkg::*;

   logic                    p_valid_ff;
   logic                    p_in_ff, p_out_ff, p_last_ff, p_ok_ff, p_rid_ff;
   logic [2*VALUE_BITS-1:0] prod_ff, prod_in;

   logic [SUM_W-1:0]        sum;
   logic [MAX_W-1:0]        bytes;
   logic [MAX_W-1:0]        max_in_ff, max_in_in;
   logic [MAX_W-1:0]        max_out_ff, max_out_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   hrds_rsp_type            rsp_word_ff, rsp_word_in;
   logic                    load;

   assign prod_in = ev.size[VALUE_BITS-1:0] * ev.count[VALUE_BITS-1:0];

   // round up to bytes; bits above the 61-bit field drop out
   assign sum   = SUM_W'(prod_ff) + SUM_W'(7);
   assign bytes = sum[MAX_W+2:3];

   always_comb begin
      max_in_in  = max_in_ff;
      max_out_in = max_out_ff;
      if (p_in_ff && (max_in_ff < bytes)) begin
         max_in_in = bytes;
      end
      if (p_out_ff && (max_out_ff < bytes)) begin
         max_out_in = bytes;
      end
      rsp_word_in.parse_ok         = p_ok_ff;
      rsp_word_in.max_input_bytes  = max_in_in;
      rsp_word_in.max_output_bytes = max_out_in;
      rsp_word_in.uses_report_id   = p_rid_ff;
   end

   assign s3_result = p_valid_ff && p_last_ff;
   assign load      = adv && s3_result;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_in_ff    <= '0;
         max_out_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            p_valid_ff <= ev.valid;
            if (p_valid_ff) begin
               if (p_last_ff) begin
                  max_in_ff  <= '0;
                  max_out_ff <= '0;
               end else begin
                  max_in_ff  <= max_in_in;
                  max_out_ff <= max_out_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_in_ff   <= ev.is_input;
         p_out_ff  <= ev.is_output;
         p_last_ff <= ev.last;
         p_ok_ff   <= ev.ok;
         p_rid_ff  <= ev.rid_seen;
         prod_ff   <= prod_in;
      end
      if (load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- sv/hid_report_descriptor_size_scan.sv -----
// Top level of the HID report descriptor size scan.
// Depends on hrds_pkg, hrds_parser and hrds_size_max.
//
// Feed the report descriptor one byte per word on the req_ channel, with
// last_byte set on its final byte; one rsp_ word follows each final byte,
// giving parse_ok, the largest Input and Output report sizes in bytes and
// whether a Report ID item appeared. The block takes one byte every clock
// while req_stall is low and holds no item back between descriptors;
// once its final byte is accepted, a result moves through the input
// register, parser event register, size product register, then the
// result register. The only time req_stall rises is when a result sits
// in the result register under rsp_stall and the next result has reached
// the product stage; then the whole pipeline holds until the result
// register frees. All parse state and both maxima return to zero after
// each final byte, so descriptors may follow back to back. VALUE_BITS sets
// the width of accumulated Report Size and Report Count values (8 to 32).
module hid_report_descriptor_size_scan #(
   parameter int VALUE_BITS = hrds_pkg::VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  hrds_pkg::hrds_req_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hrds_pkg::hrds_rsp_type rsp_word
);
   import hrds_pkg::*;

   hrds_event_type ev;
   logic           s3_result;
   logic           adv;

   // Advance everything unless a finished result would overrun a held one.
   assign adv       = !(rsp_valid && rsp_stall && s3_result);
   assign req_stall = !adv;

   hrds_parser #(
      .VALUE_BITS(VALUE_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_word  (req_word),
      .ev        (ev)
   );

   hrds_size_max #(
      .VALUE_BITS(VALUE_BITS)
   ) u_size_max (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .ev        (ev),
      .rsp_stall (rsp_stall),
      .s3_result (s3_result),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- sv/hrds_checker.sv -----
// Port-level checks for the HID report descriptor size scan, bound to the top.
// Depends on hrds_pkg and hid_report_descriptor_size_scan.
module hrds_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input hrds_pkg::hrds_req_type req_word,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input hrds_pkg::hrds_rsp_type rsp_word
);
   import hrds_pkg::*;

   logic       last_acc;
   logic       rsp_acc;
   logic [2:0] pend_ff, pend_in;

   assign last_acc = req_valid && !req_stall && req_word.last_byte;
   assign rsp_acc  = rsp_valid && !rsp_stall;

   // final bytes taken whose result is still owed
   always_comb begin
      pend_in = pend_ff;
      if (last_acc && !rsp_acc) begin
         pend_in = pend_ff + 3'd1;
      end else if (!last_acc && rsp_acc) begin
         pend_in = pend_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 3'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 3'd0))
      else $error("result without an owed final byte");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd4)
      else $error("more results owed than pipeline stages");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while result register empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result changed or dropped");

endmodule

bind hid_report_descriptor_size_scan hrds_checker u_hrds_checker (.*);
